// ===== hdl/dtq_pkg.sv =====
// Shared types and constants of the deadline timer queue.
// Depends on nothing; used by every module of the block.
package dtq_pkg;

	localparam int TIME_W = 48;
	localparam int PER_W  = 40;
	localparam int ID_W   = 8;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic              op;
		logic [ID_W-1:0]   timer_id;
		logic [TIME_W-1:0] deadline;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] now_time;
	} in_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   fired_id;
		logic              fired_valid;
		logic              last;
		logic              earliest_changed;
		logic              dropped_full;
		logic [TIME_W-1:0] next_deadline;
		logic              next_valid;
	} out_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] deadline;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} chain_cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] redl;
	} popped_t;

endpackage

// ===== hdl/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: control sequencer, popped-timer memory
// and result register. Depends on dtq_pkg and dtq_chain.
//
// An add goes into the chain as it is accepted, unless the chain is full, and
// its single result is registered in S_ADD_OUT. A tick pops every expired timer
// off the chain into the popped memory, then reads each back and reinserts it if
// its period is nonzero, then reads each again to deliver its result; a tick that
// pops nothing answers from S_TICK_OUT. The chain inserts or pops one word per
// cycle, and the single read port of the popped memory puts a read state before
// each reinsert and each result. Results are strobed for one cycle and cannot be
// stalled, and busy stays high until the last result of an item has been registered.
module deadline_timer_queue #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dtq_pkg::in_word_t  item,
	output logic               busy,
	output logic               strobe,
	output dtq_pkg::out_word_t res
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_ADD_OUT  = 8'b0000_0010,
		S_POP      = 8'b0000_0100,
		S_REIN_RD  = 8'b0000_1000,
		S_REIN_INS = 8'b0001_0000,
		S_EMIT_RD  = 8'b0010_0000,
		S_EMIT_OUT = 8'b0100_0000,
		S_TICK_OUT = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       idx_q;
	logic                ec_q;
	logic                df_q;
	logic [dtq_pkg::TIME_W-1:0] now_q;
	dtq_pkg::popped_t    mem_q [CAPACITY];
	dtq_pkg::popped_t    rd_q;
	dtq_pkg::out_word_t  res_q;
	logic                strobe_q;

	dtq_pkg::chain_cmd_t cmd;
	dtq_pkg::entry_t     new_entry;
	dtq_pkg::entry_t     head;
	logic                head_used;
	logic                tail_used;
	logic                accept;
	logic                expire;
	logic [dtq_pkg::TIME_W:0]   sum;
	logic [dtq_pkg::TIME_W-1:0] redl;
	logic                is_last;

	dtq_chain #(.CAPACITY(CAPACITY)) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.new_entry (new_entry),
		.head      (head),
		.head_used (head_used),
		.tail_used (tail_used)
	);

	assign accept  = start && (state_q == S_IDLE);
	assign expire  = head_used && (head.deadline <= now_q);
	assign sum     = {1'b0, now_q} + {{(dtq_pkg::TIME_W + 1 - dtq_pkg::PER_W){1'b0}}, head.period};
	assign redl    = sum[dtq_pkg::TIME_W] ? '1 : sum[dtq_pkg::TIME_W-1:0];
	assign is_last = (idx_q == (n_q - CW'(1)));

	always_comb begin
		cmd       = '0;
		new_entry = '0;
		case (state_q)
			S_IDLE: begin
				cmd.ins            = accept && (item.op == dtq_pkg::OP_ADD) && !tail_used;
				new_entry.id       = item.timer_id;
				new_entry.period   = item.period;
				new_entry.deadline = item.deadline;
			end
			S_POP: begin
				cmd.pop = expire;
			end
			S_REIN_INS: begin
				cmd.ins            = (rd_q.period != '0);
				new_entry.id       = rd_q.id;
				new_entry.period   = rd_q.period;
				new_entry.deadline = rd_q.redl;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_POP && expire) begin
			mem_q[n_q[IW-1:0]] <= '{id: head.id, period: head.period, redl: redl};
		end
		rd_q <= mem_q[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= item.now_time;
			ec_q  <= !tail_used && (!head_used || (item.deadline < head.deadline));
			df_q  <= tail_used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
			res_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q     <= '0;
						idx_q   <= '0;
						state_q <= (item.op == dtq_pkg::OP_ADD) ? S_ADD_OUT : S_POP;
					end
				end
				S_ADD_OUT: begin
					res_q    <= '{fired_id: '0, fired_valid: 1'b0, last: 1'b1,
						earliest_changed: ec_q, dropped_full: df_q,
						next_deadline: head_used ? head.deadline : '0,
						next_valid: head_used};
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_POP: begin
					if (expire) begin
						n_q <= n_q + CW'(1);
					end else if (n_q == '0) begin
						state_q <= S_TICK_OUT;
					end else begin
						state_q <= S_REIN_RD;
					end
				end
				S_REIN_RD: begin
					state_q <= S_REIN_INS;
				end
				S_REIN_INS: begin
					if (is_last) begin
						idx_q   <= '0;
						state_q <= S_EMIT_RD;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_REIN_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					res_q    <= '{fired_id: rd_q.id, fired_valid: 1'b1, last: is_last,
						earliest_changed: 1'b0, dropped_full: 1'b0,
						next_deadline: head_used ? head.deadline : '0,
						next_valid: head_used};
					strobe_q <= 1'b1;
					idx_q    <= idx_q + CW'(1);
					state_q  <= is_last ? S_IDLE : S_EMIT_RD;
				end
				S_TICK_OUT: begin
					res_q    <= '{fired_id: '0, fired_valid: 1'b0, last: 1'b1,
						earliest_changed: 1'b0, dropped_full: 1'b0,
						next_deadline: head_used ? head.deadline : '0,
						next_valid: head_used};
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign res    = res_q;

endmodule

// ===== hdl/dtq_cell.sv =====
// One slot of the sorted timer chain.
// Depends on dtq_pkg; instantiated by dtq_chain.
module dtq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dtq_pkg::chain_cmd_t cmd,
	input  dtq_pkg::entry_t    new_entry,
	input  dtq_pkg::entry_t    left_entry,
	input  logic               left_used,
	input  logic               left_gt,
	input  dtq_pkg::entry_t    right_entry,
	input  logic               right_used,
	output dtq_pkg::entry_t    entry,
	output logic               used,
	output logic               gt
);

	dtq_pkg::entry_t entry_q;
	logic            used_q;

	// The new word goes in front of this slot when the slot is empty or later.
	assign gt    = !used_q || (entry_q.deadline > new_entry.deadline);
	assign entry = entry_q;
	assign used  = used_q;

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			entry_q <= right_entry;
		end else if (cmd.ins && gt) begin
			entry_q <= left_gt ? left_entry : new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.pop) begin
			used_q <= right_used;
		end else if (cmd.ins && gt) begin
			used_q <= left_gt ? left_used : 1'b1;
		end
	end

endmodule

// ===== hdl/dtq_chain.sv =====
// Row of timer slots kept in deadline order, slot 0 earliest.
// Depends on dtq_pkg and dtq_cell; instantiated by deadline_timer_queue.
module dtq_chain #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dtq_pkg::chain_cmd_t cmd,
	input  dtq_pkg::entry_t     new_entry,
	output dtq_pkg::entry_t     head,
	output logic                head_used,
	output logic                tail_used
);

	dtq_pkg::entry_t ent_w [CAPACITY];
	logic            used_w [CAPACITY];
	logic            gt_w [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		dtq_pkg::entry_t lft_e;
		dtq_pkg::entry_t rgt_e;
		logic            lft_u;
		logic            lft_g;
		logic            rgt_u;

		if (i == 0) begin : g_first
			assign lft_e = '0;
			assign lft_u = 1'b0;
			assign lft_g = 1'b0;
		end else begin : g_mid
			assign lft_e = ent_w[i-1];
			assign lft_u = used_w[i-1];
			assign lft_g = gt_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rgt_e = '0;
			assign rgt_u = 1'b0;
		end else begin : g_inner
			assign rgt_e = ent_w[i+1];
			assign rgt_u = used_w[i+1];
		end

		dtq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.new_entry   (new_entry),
			.left_entry  (lft_e),
			.left_used   (lft_u),
			.left_gt     (lft_g),
			.right_entry (rgt_e),
			.right_used  (rgt_u),
			.entry       (ent_w[i]),
			.used        (used_w[i]),
			.gt          (gt_w[i])
		);
	end

	assign head      = ent_w[0];
	assign head_used = used_w[0];
	assign tail_used = used_w[CAPACITY-1];

endmodule

// ===== hdl/dtq_checker.sv =====
// Port-level checks of the deadline timer queue, bound to the top level.
// Depends on dtq_pkg and deadline_timer_queue.
module dtq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               strobe,
	input dtq_pkg::out_word_t res
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_nofire_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !res.fired_valid) |-> res.last)
		else $error("result without a fired timer is not the last one");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !res.last) |-> busy)
		else $error("block went idle before the last result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !res.next_valid) |-> (res.next_deadline == '0))
		else $error("empty queue reports a nonzero next deadline");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(res.earliest_changed && (res.dropped_full || res.fired_valid)))
		else $error("add flags mixed with a dropped add or a fired timer");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.res    (res)
);

// ===== dv/deadline_timer_queue_tb.sv =====
// Self-checking testbench for the deadline timer queue: directed and random adds and ticks.
// Keeps its own ordered timer list to predict every result word and compares each strobed word.
// Depends on dtq_pkg and the deadline_timer_queue RTL.
module deadline_timer_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIME_W = dtq_pkg::TIME_W;
	localparam int PER_W  = dtq_pkg::PER_W;
	localparam int ID_W   = dtq_pkg::ID_W;

	localparam int DEPTH = 16;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [PER_W-1:0] PER_MAX = '1;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] due;
		logic [PER_W-1:0]  period;
	} timer_rec_t;

	logic clk;
	logic arst_n;
	logic start;
	dtq_pkg::in_word_t item;
	logic busy;
	logic strobe;
	dtq_pkg::out_word_t res;

	timer_rec_t timer_list[$];
	dtq_pkg::out_word_t expected_words[$];
	logic [TIME_W-1:0] base_now;
	int idle_pct;
	int n_errors;
	int n_adds;
	int n_drops;
	int n_ticks;
	int n_fired;
	int n_reloads;
	int most_fired;

	deadline_timer_queue #(.CAPACITY(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.res    (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[TIME_W-1:0];
	endfunction

	function automatic logic [PER_W-1:0] rand40();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[PER_W-1:0];
	endfunction

	function automatic void note_error(string msg);
		n_errors++;
		if (n_errors <= 10) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endfunction

	function automatic void insert_timer(timer_rec_t t);
		int pos;
		pos = 0;
		while (pos < timer_list.size() && timer_list[pos].due <= t.due) begin
			pos++;
		end
		timer_list.insert(pos, t);
	endfunction

	function automatic void predict_item(dtq_pkg::in_word_t w);
		timer_rec_t t;
		timer_rec_t fired[$];
		dtq_pkg::out_word_t outs[$];
		dtq_pkg::out_word_t r;
		logic [TIME_W:0] sum;
		r = '0;
		if (w.op == dtq_pkg::OP_ADD) begin
			n_adds++;
			r.last = 1'b1;
			if (timer_list.size() >= DEPTH) begin
				r.dropped_full = 1'b1;
				n_drops++;
			end else begin
				r.earliest_changed = (timer_list.size() == 0) || (w.deadline < timer_list[0].due);
				t.id = w.timer_id;
				t.due = w.deadline;
				t.period = w.period;
				insert_timer(t);
			end
			outs.push_back(r);
		end else begin
			n_ticks++;
			while (timer_list.size() > 0 && timer_list[0].due <= w.now_time) begin
				fired.push_back(timer_list.pop_front());
			end
			foreach (fired[i]) begin
				if (fired[i].period != '0) begin
					sum = (TIME_W + 1)'(w.now_time) + (TIME_W + 1)'(fired[i].period);
					t = fired[i];
					t.due = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
					insert_timer(t);
					n_reloads++;
				end
			end
			if (fired.size() == 0) begin
				r.last = 1'b1;
				outs.push_back(r);
			end
			foreach (fired[i]) begin
				r.fired_id = fired[i].id;
				r.fired_valid = 1'b1;
				r.last = (i == fired.size() - 1);
				outs.push_back(r);
			end
			n_fired += fired.size();
			if (fired.size() > most_fired) begin
				most_fired = fired.size();
			end
		end
		foreach (outs[i]) begin
			outs[i].next_valid = (timer_list.size() > 0);
			outs[i].next_deadline = (timer_list.size() > 0) ? timer_list[0].due : '0;
			expected_words.push_back(outs[i]);
		end
	endfunction

	function automatic void compare_field(string name, logic [TIME_W-1:0] want,
		logic [TIME_W-1:0] got);
		if (got !== want) begin
			note_error($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
		end
	endfunction

	always @(posedge clk) begin : check_results
		dtq_pkg::out_word_t want;
		if (arst_n && strobe) begin
			if (expected_words.size() == 0) begin
				note_error($sformatf("result word with nothing pending: %p", res));
			end else begin
				want = expected_words.pop_front();
				compare_field("fired_id", TIME_W'(want.fired_id), TIME_W'(res.fired_id));
				compare_field("fired_valid", TIME_W'(want.fired_valid),
					TIME_W'(res.fired_valid));
				compare_field("last", TIME_W'(want.last), TIME_W'(res.last));
				compare_field("earliest_changed", TIME_W'(want.earliest_changed),
					TIME_W'(res.earliest_changed));
				compare_field("dropped_full", TIME_W'(want.dropped_full),
					TIME_W'(res.dropped_full));
				compare_field("next_deadline", want.next_deadline, res.next_deadline);
				compare_field("next_valid", TIME_W'(want.next_valid), TIME_W'(res.next_valid));
			end
		end
	end

	// Called at a falling edge; returns at a falling edge after the word is taken.
	task automatic send_word(dtq_pkg::in_word_t w);
		int gap;
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		predict_item(w);
		@(negedge clk);
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic add_timer(logic [ID_W-1:0] id, logic [TIME_W-1:0] dl, logic [PER_W-1:0] per);
		dtq_pkg::in_word_t w;
		w.op = dtq_pkg::OP_ADD;
		w.timer_id = id;
		w.deadline = dl;
		w.period = per;
		w.now_time = rand48();
		send_word(w);
	endtask

	task automatic tick_at(logic [TIME_W-1:0] now_t);
		dtq_pkg::in_word_t w;
		w.op = dtq_pkg::OP_TICK;
		w.timer_id = ID_W'($urandom_range(255));
		w.deadline = rand48();
		w.period = rand40();
		w.now_time = now_t;
		send_word(w);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_words.size() > 0) begin
			@(negedge clk);
		end
	endtask

	task automatic test_empty_tick();
		tick_at('0);
	endtask

	task automatic test_ties_and_order();
		add_timer(8'h00, '0, '0);
		add_timer(8'hFF, '0, PER_MAX);
		add_timer(8'hAA, TIME_MAX, '0);
		tick_at('0);
	endtask

	task automatic test_saturation();
		tick_at(TIME_MAX - TIME_W'(1));
		tick_at(TIME_MAX);
	endtask

	task automatic test_full_queue();
		repeat (DEPTH - timer_list.size()) begin
			add_timer(ID_W'($urandom_range(255)), rand48(), '0);
		end
		add_timer(8'h5A, '0, PER_MAX);
		tick_at(TIME_MAX);
	endtask

	task automatic test_random_traffic(int count, int pct);
		logic [TIME_W-1:0] dl;
		logic [PER_W-1:0] per;
		int sel;
		idle_pct = pct;
		repeat (count) begin
			if ($urandom_range(99) < ((timer_list.size() < 4) ? 70 : 50)) begin
				sel = $urandom_range(9);
				if (sel <= 5) begin
					dl = base_now + TIME_W'($urandom_range(300));
				end else if (sel == 6) begin
					dl = rand48();
				end else if (sel == 7) begin
					dl = (timer_list.size() > 0) ? timer_list[0].due : base_now;
				end else if (sel == 8) begin
					dl = TIME_MAX;
				end else begin
					dl = base_now;
				end
				sel = $urandom_range(99);
				if (sel < 90) begin
					per = '0;
				end else if (sel < 97) begin
					per = PER_W'($urandom_range(1, 200));
				end else if (sel < 99) begin
					per = rand40();
				end else begin
					per = PER_MAX;
				end
				add_timer(ID_W'($urandom_range(255)), dl, per);
			end else begin
				sel = $urandom_range(19);
				if (sel == 0) begin
					tick_at(rand48());
				end else if (sel == 1) begin
					tick_at(base_now - TIME_W'($urandom_range(50)));
				end else begin
					base_now = base_now + TIME_W'($urandom_range(120));
					tick_at(base_now);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		idle_pct = 0;
		base_now = '0;
		n_errors = 0;
		n_adds = 0;
		n_drops = 0;
		n_ticks = 0;
		n_fired = 0;
		n_reloads = 0;
		most_fired = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_tick();
		test_ties_and_order();
		test_saturation();
		test_full_queue();
		drain_results();

		test_random_traffic(100, 0);
		drain_results();
		test_random_traffic(100, 81);
		drain_results();
		test_random_traffic(86, 6);
		drain_results();
		repeat (20) @(negedge clk);

		if (expected_words.size() != 0) begin
			note_error($sformatf("%0d result words never arrived", expected_words.size()));
		end
		$display("Sent %0d adds (%0d refused on a full queue) and %0d ticks.",
			n_adds, n_drops, n_ticks);
		$display("%0d timers fired, %0d reloaded, up to %0d in one tick; %0d mismatches.",
			n_fired, n_reloads, most_fired, n_errors);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/dtq_pkg.sv
hdl/dtq_cell.sv
hdl/dtq_chain.sv
hdl/deadline_timer_queue.sv
hdl/dtq_checker.sv
dv/deadline_timer_queue_tb.sv
